// ===== hw/rtl/rpt_pkg.sv =====
// shared types and constants for the resonance phase tracker
package rpt_pkg;
    localparam int unsigned FREQ_W = 27;
    localparam int unsigned FREQ_MAX = 100000000;
    localparam int unsigned FREQ_RESET = 289660;
    localparam int unsigned DIV_RESET = 10;
    localparam int unsigned CLOCK_HZ_DEFAULT = 16000000;
    localparam logic [27:0] STEP_Q24 = 28'd225179981;
    localparam logic [15:0] CTRL_REG0 = 16'h2000;
    localparam logic [15:0] CTRL_REG1 = 16'h2800;
    localparam logic [15:0] DATA_TAG = 16'h4000;
    localparam logic [1:0] ADDR_START = 2'd0;
    localparam logic [1:0] ADDR_DIV = 2'd1;
    localparam logic [1:0] ADDR_SEL = 2'd2;
    localparam int unsigned DIV_STEPS = 56;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DIV_Q, ST_DIV_L, ST_UPDATE, ST_MUL, ST_DIV_W,
        ST_OUT0, ST_OUT1, ST_OUT2
    } state_t;

    typedef enum logic [1:0] {
        DIV_Q, DIV_L, DIV_W
    } div_sel_t;

    typedef struct packed {
        logic       load;
        logic       div_start;
        div_sel_t   div_sel;
        logic       div_step;
        logic       update;
        logic       mul;
    } cmd_t;

    typedef struct packed {
        logic div_done;
    } status_t;
endpackage

// ===== hw/rtl/rpt_ctrl.sv =====
// sequencer for one update: three divisions, update, multiply, three output items
module rpt_ctrl import rpt_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output logic    last_word,
    output logic [1:0] word_sel,
    output cmd_t    cmd,
    input  status_t status
);
    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.div_sel = DIV_Q;
        in_ready = 1'b0;
        out_valid = 1'b0;
        last_word = 1'b0;
        word_sel = 2'd0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel = DIV_Q;
                    state_next = ST_DIV_Q;
                end
            end
            ST_DIV_Q:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    cmd.div_step = 1'b0;
                    cmd.div_start = 1'b1;
                    cmd.div_sel = DIV_L;
                    state_next = ST_DIV_L;
                end
            end
            ST_DIV_L:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    cmd.div_step = 1'b0;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul = 1'b1;
                cmd.div_start = 1'b1;
                cmd.div_sel = DIV_W;
                state_next = ST_DIV_W;
            end
            ST_DIV_W:
            begin
                cmd.div_step = 1'b1;
                if (status.div_done)
                begin
                    cmd.div_step = 1'b0;
                    state_next = ST_OUT0;
                end
            end
            ST_OUT0:
            begin
                out_valid = 1'b1;
                word_sel = 2'd0;
                if (out_ready) state_next = ST_OUT1;
            end
            ST_OUT1:
            begin
                out_valid = 1'b1;
                word_sel = 2'd1;
                if (out_ready) state_next = ST_OUT2;
            end
            ST_OUT2:
            begin
                out_valid = 1'b1;
                word_sel = 2'd2;
                last_word = 1'b1;
                if (out_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    a_out_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("output item while taking input");
    a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && last_word) |=> in_ready)
        else $error("no return to idle after last word");
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(word_sel)))
        else $error("stalled output item changed");
endmodule

// ===== hw/rtl/rpt_datapath.sv =====
// frequency state, config registers, shared serial divider and word build
module rpt_datapath import rpt_pkg::*; #(
    parameter int unsigned CLOCK_HZ = CLOCK_HZ_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_data,
    output logic [31:0] cfg_rdata,
    input  logic [15:0] phase_ticks,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [1:0]  word_sel,
    output logic [15:0] spi_word,
    output logic [FREQ_W-1:0] frequency
);
    localparam int unsigned DW = 56;
    localparam int unsigned CW = $clog2(DIV_STEPS + 1);
    localparam logic [DW-1:0] CLK_V = DW'(CLOCK_HZ);

    logic [FREQ_W-1:0] start_reg, cur_freq_reg;
    logic [7:0]  div_reg;
    logic        sel_reg;
    logic [15:0] phase_reg;
    logic [DW-1:0] num_reg, den_reg, quo_reg;
    logic [DW:0]   rem_reg;
    logic [CW-1:0] cnt_reg;
    logic [26:0] q_reg;
    logic [27:0] word_reg;

    logic [7:0] d_eff;
    logic [26:0] start_clamp;
    logic [DW:0] rem_shift;
    logic [15:0] lambda, target, diff;
    logic signed [28:0] sum;

    assign d_eff = (div_reg == 8'd0) ? 8'd1 : div_reg;
    assign start_clamp = (cfg_data[26:0] > 27'(FREQ_MAX)) ? 27'(FREQ_MAX) : cfg_data[26:0];
    assign rem_shift = {rem_reg[DW-1:0], num_reg[DW-1]};
    assign status.div_done = (cnt_reg == CW'(DIV_STEPS));

    // saturate the lambda quotient to 16 bits
    always_comb
    begin
        if (q_reg == 27'd0 || quo_reg > 56'hFFFF) lambda = 16'hFFFF;
        else lambda = quo_reg[15:0];
        target = {1'b0, lambda[15:1]} + {4'b0, lambda[15:4]};
        diff = target - phase_reg;
        sum = $signed({2'b0, cur_freq_reg}) + 29'(signed'(diff));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg    <= 27'(FREQ_RESET);
            cur_freq_reg <= 27'(FREQ_RESET);
            div_reg      <= 8'(DIV_RESET);
            sel_reg      <= 1'b0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    ADDR_START:
                    begin
                        start_reg    <= start_clamp;
                        cur_freq_reg <= start_clamp;
                    end
                    ADDR_DIV: div_reg <= cfg_data[7:0];
                    ADDR_SEL: sel_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (cmd.div_start) cnt_reg <= '0;
            else if (cmd.div_step && !status.div_done) cnt_reg <= cnt_reg + 1'b1;
            if (cmd.update)
            begin
                if (sum < 0) cur_freq_reg <= '0;
                else if (sum > 29'sd100000000) cur_freq_reg <= 27'(FREQ_MAX);
                else cur_freq_reg <= sum[26:0];
            end
        end
    end

    // restoring divider, one quotient bit per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.load) phase_reg <= phase_ticks;
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= '0;
            unique case (cmd.div_sel)
                DIV_Q:
                begin
                    num_reg <= DW'(cur_freq_reg);
                    den_reg <= DW'(d_eff);
                end
                DIV_L:
                begin
                    q_reg <= quo_reg[26:0];
                    num_reg <= CLK_V;
                    den_reg <= (quo_reg == '0) ? DW'(1) : quo_reg;
                end
                DIV_W:
                begin
                    // numerator comes from the multiply in the same cycle
                    den_reg <= {d_eff, 24'd0};
                end
                default: ;
            endcase
        end
        else if (cmd.div_step && !status.div_done)
        begin
            num_reg <= {num_reg[DW-2:0], 1'b0};
            if (rem_shift >= {1'b0, den_reg})
            begin
                rem_reg <= rem_shift - {1'b0, den_reg};
                quo_reg <= {quo_reg[DW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_shift;
                quo_reg <= {quo_reg[DW-2:0], 1'b0};
            end
        end
        if (cmd.mul) num_reg <= DW'(cur_freq_reg) * DW'(STEP_Q24);
        if (status.div_done && cmd.div_step == 1'b0 && !cmd.div_start)
            word_reg <= quo_reg[27:0];
    end

    always_comb
    begin
        unique case (word_sel)
            2'd0: spi_word = sel_reg ? CTRL_REG1 : CTRL_REG0;
            2'd1: spi_word = DATA_TAG + {2'b0, word_reg[13:0]};
            default: spi_word = DATA_TAG + {2'b0, word_reg[27:14]};
        endcase
        unique case (cfg_addr)
            ADDR_START: cfg_rdata = 32'(start_reg);
            ADDR_DIV: cfg_rdata = 32'(div_reg);
            ADDR_SEL: cfg_rdata = 32'(sel_reg);
            default: cfg_rdata = '0;
        endcase
    end
    assign frequency = cur_freq_reg;
endmodule

// ===== hw/rtl/resonance_phase_tracker.sv =====
// top level of the resonance phase tracker
// usage:
//   - in channel (in_valid/in_ready, phase_ticks) takes one phase delay item
//     when the block is idle
//   - each item yields three out items (spi_word, last_word, frequency):
//     control word, low 14 tuning bits, high 14 tuning bits
//   - work per item: a period division, a lambda division and a tuning word
//     division share one restoring divider (56 steps each, then a done
//     state), plus an update step and a multiply step
//   - the out channel holds each item until taken; a stall just waits
//   - items are sequential: the next one is accepted after the third word
//   - apb port: start_frequency at 0x0, accuracy_divisor at 0x4,
//     register_select at 0x8; writing start_frequency reloads the frequency
//   - reset loads the default registers and returns to idle
module resonance_phase_tracker import rpt_pkg::*; #(
    parameter int unsigned CLOCK_HZ = CLOCK_HZ_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] phase_ticks,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] spi_word,
    output logic        last_word,
    output logic [FREQ_W-1:0] frequency
);
    cmd_t    cmd;
    status_t status;
    logic [1:0] word_sel;
    logic cfg_we;

    assign pready = 1'b1;
    // unknown addresses fall to the default arm in the datapath
    assign cfg_we = psel && penable && pwrite && pready;

    rpt_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .out_valid(out_valid), .out_ready(out_ready), .last_word(last_word),
        .word_sel(word_sel), .cmd(cmd), .status(status)
    );

    rpt_datapath #(.CLOCK_HZ(CLOCK_HZ)) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_addr(paddr[3:2]),
        .cfg_data(pwdata), .cfg_rdata(prdata), .phase_ticks(phase_ticks),
        .cmd(cmd), .status(status), .word_sel(word_sel), .spi_word(spi_word),
        .frequency(frequency)
    );
endmodule
